// File: rtl/spq_pkg.sv
// spq_pkg: shared types and codes for the sorted priority queue
// request and response beats, cell entry, cell command, cell position, sequencer states
// no dependencies
package spq_pkg;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam int unsigned FILL_W = 5;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] item_data;
    logic signed [31:0] item_key;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_data;
    logic signed [31:0] out_key;
    logic [1:0]         status;
    logic [FILL_W-1:0]  fill_count;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic signed [31:0] key;
  } entry_t;

  // broadcast to every cell in the row
  typedef struct packed {
    logic   ins;
    logic   del;
    entry_t new_entry;
  } cell_cmd_t;

  // where a cell sits relative to the current fill level
  typedef struct packed {
    logic occupied;
    logic at_tail;
  } cell_pos_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

// File: rtl/spq_cell.sv
// spq_cell: one slot of the sorted row, holds a single entry
// compares its key with the incoming key and shifts left or right on command
// depends on spq_pkg
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_cmd_t cmd,
  input  spq_pkg::cell_pos_t pos,
  input  spq_pkg::entry_t    left_entry,
  input  logic               left_ge,
  input  spq_pkg::entry_t    right_entry,
  output spq_pkg::entry_t    entry,
  output logic               ge
);

  // row is sorted, so ge is monotone along the occupied cells
  assign ge = pos.occupied && (entry.key >= cmd.new_entry.key);

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (left_ge) begin
        entry <= left_entry;
      end else if (ge || pos.at_tail) begin
        entry <= cmd.new_entry;
      end
    end else if (cmd.del) begin
      entry <= right_entry;
    end
  end

endmodule

// File: rtl/sorted_priority_queue_unit.sv
// sorted_priority_queue_unit: top level of the min-first sorted priority queue
// a row of spq_cell slots plus the request sequencer and response register
// depends on spq_pkg and spq_cell
//
// The queue holds up to QUEUE_DEPTH entries (data and signed key) in a row of
// cells kept in ascending key order, smallest at cell 0. An enqueue beat puts
// its entry in front of the first stored entry whose key is greater than or
// equal to its own, so the newest wins among equal keys; a dequeue beat pops
// cell 0. Every request beat gives exactly one response beat carrying the
// popped entry (zero otherwise), a status (done, dequeue on empty, enqueue
// dropped because full) and the fill level after the request, the low five
// bits of the count. After a beat is captured, every cell compares its key
// with the new one in parallel and the entries from the insertion point, or
// all on a dequeue, shift by one slot. The row update waits while the
// previous response has not been taken, so a stalled response holds the
// next request in its capture register. No clearing pass after reset: cells
// above the fill level are never read, only the entry count is reset.
module sorted_priority_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  spq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output spq_pkg::rsp_t rsp
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  spq_pkg::state_t state, state_next;
  spq_pkg::req_t   pending;
  logic [CW-1:0]   count, count_next;
  spq_pkg::rsp_t   rsp_next;
  logic            do_op;
  logic            is_full, is_empty;
  logic [CW+spq_pkg::FILL_W-1:0] count_ext;

  spq_pkg::cell_cmd_t cmd;
  spq_pkg::entry_t    cell_entry [QUEUE_DEPTH];
  logic               cell_ge    [QUEUE_DEPTH];

  // capture register for the request beat
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      pending <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // row update only when the response slot is free or being emptied
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    do_op      = 1'b0;
    case (state)
      spq_pkg::ST_IDLE: begin
        req_ready = !rst;
        if (req_valid && !rst) begin
          state_next = spq_pkg::ST_EXEC;
        end
      end
      spq_pkg::ST_EXEC: begin
        if (!rsp_valid || rsp_ready) begin
          do_op      = 1'b1;
          state_next = spq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spq_pkg::ST_IDLE;
      end
    endcase
  end

  assign is_full  = (count == CW'(QUEUE_DEPTH));
  assign is_empty = (count == '0);

  // commands broadcast to the cell row
  always_comb begin
    cmd.ins            = do_op && (pending.req_type == spq_pkg::REQ_ENQ) && !is_full;
    cmd.del            = do_op && (pending.req_type == spq_pkg::REQ_DEQ) && !is_empty;
    cmd.new_entry.data = pending.item_data;
    cmd.new_entry.key  = pending.item_key;
  end

  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + CW'(1);
    end else if (cmd.del) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // fill level reported as the low five bits of the count
  assign count_ext = {{spq_pkg::FILL_W{1'b0}}, count_next};

  // response built from the head cell before the row shifts
  always_comb begin
    rsp_next.out_data   = '0;
    rsp_next.out_key    = '0;
    rsp_next.status     = spq_pkg::STATUS_DONE;
    rsp_next.fill_count = count_ext[spq_pkg::FILL_W-1:0];
    if (pending.req_type == spq_pkg::REQ_ENQ) begin
      if (is_full) begin
        rsp_next.status = spq_pkg::STATUS_FULL;
      end
    end else if (is_empty) begin
      rsp_next.status = spq_pkg::STATUS_EMPTY;
    end else begin
      rsp_next.out_data = cell_entry[0].data;
      rsp_next.out_key  = cell_entry[0].key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (do_op) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_op) begin
      rsp <= rsp_next;
    end
  end

  // the cell row: each cell sees its left neighbour for insertion shifts
  // and its right neighbour for removal shifts
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_pkg::cell_pos_t pos;
    spq_pkg::entry_t    left_entry;
    spq_pkg::entry_t    right_entry;
    logic               left_ge;

    assign pos.occupied = (CW'(i) < count);
    assign pos.at_tail  = (CW'(i) == count);

    if (i == 0) begin : g_head
      assign left_entry = cmd.new_entry;
      assign left_ge    = 1'b0;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_ge    = cell_ge[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .pos         (pos),
      .left_entry  (left_entry),
      .left_ge     (left_ge),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .ge          (cell_ge[i])
    );
  end

endmodule

// File: rtl/spq_checker.sv
// spq_checker: port-level checks for sorted_priority_queue_unit
// attached to the top level by the bind statement at the end of this file
// depends on spq_pkg
module spq_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input spq_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input spq_pkg::rsp_t rsp
);

  // one request in flight: ready drops right after a beat is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while previous one in flight");

  // a response only rises after a taken request beat has dropped ready
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("response beat without request");

  // a waiting request beat is held steady by the sender
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_ready) |=> (req_valid && $stable(req)))
    else $error("request beat changed while waiting");

  // failed requests carry no entry
  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != spq_pkg::STATUS_DONE) |->
      (rsp.out_data == '0 && rsp.out_key == '0))
    else $error("entry fields not zero on failed request");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("response beat changed while stalled");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

// File: tb/sv/spq_tb_pkg.sv
`timescale 1ns / 100ps
// spq_tb_pkg: sorted queue tracker that predicts and checks response beats
// depends on spq_pkg for the request, response and entry types
package spq_tb_pkg;

  class sorted_queue_tracker;
    int unsigned      depth;
    spq_pkg::entry_t  held[$];     // mirror of the row, smallest key first
    spq_pkg::rsp_t    rsp_due[$];  // responses still to arrive, oldest first
    int unsigned      fails;

    function new(int unsigned depth_i);
      depth = depth_i;
      fails = 0;
    endfunction

    // work out the response to one request and update the mirror
    function spq_pkg::rsp_t next_response(spq_pkg::req_t r);
      spq_pkg::rsp_t   o;
      spq_pkg::entry_t e;
      int unsigned     pos;
      int unsigned     n;
      o = '0;
      o.status = spq_pkg::STATUS_DONE;
      if (r.req_type == spq_pkg::REQ_ENQ) begin
        if (held.size() >= depth) begin
          o.status = spq_pkg::STATUS_FULL;
        end else begin
          pos = held.size();
          for (int i = 0; i < held.size(); i++) begin
            if ($signed(held[i].key) >= $signed(r.item_key)) begin
              pos = i;
              break;
            end
          end
          e.data = r.item_data;
          e.key  = r.item_key;
          held.insert(pos, e);
        end
      end else if (held.size() == 0) begin
        o.status = spq_pkg::STATUS_EMPTY;
      end else begin
        e = held.pop_front();
        o.out_data = e.data;
        o.out_key  = e.key;
      end
      n = held.size();
      o.fill_count = n[spq_pkg::FILL_W-1:0];
      return o;
    endfunction

    function void note_request(spq_pkg::req_t r);
      rsp_due.push_back(next_response(r));
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        fails++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_response(spq_pkg::rsp_t a);
      spq_pkg::rsp_t e;
      if (rsp_due.size() == 0) begin
        fails++;
        $display("%0t: response beat with none expected, got %0h", $time, a);
        return;
      end
      e = rsp_due.pop_front();
      compare_field("out_data", e.out_data, a.out_data);
      compare_field("out_key", e.out_key, a.out_key);
      compare_field("status", 32'(e.status), 32'(a.status));
      compare_field("fill_count", 32'(e.fill_count), 32'(a.fill_count));
    endfunction
  endclass

endpackage

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// tb: regression for sorted_priority_queue_unit, directed beats then random phases
// depends on spq_pkg, spq_tb_pkg and the sorted_priority_queue_unit rtl
module tb;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned LONG_HOLD    = 120;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic          clk;
  logic          rst;
  logic          req_valid;
  logic          req_ready;
  spq_pkg::req_t req;
  logic          rsp_valid;
  logic          rsp_ready;
  spq_pkg::rsp_t rsp;

  spq_tb_pkg::sorted_queue_tracker tracker;

  // calm phases: no random gaps on either side
  bit          calm     = 1'b0;
  // long hold on the response side, handed to the receiver process
  int unsigned hold_req = 0;
  int unsigned cycles   = 0;

  sorted_priority_queue_unit #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("sorted_priority_queue_unit regression: fail");
        $finish;
      end
    end
  end

  // gap length: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  // keys: a narrow band for plenty of ties, the extremes, or anything at all
  function automatic logic signed [31:0] pick_key();
    int k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        k = int'($urandom_range(0, 8)) - 4;
        return k;
      end
      4: begin
        case ($urandom_range(0, 5))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh8000_0001;
          3: return 32'sh7fff_fffe;
          4: return 32'sh0000_0000;
          default: return 32'shffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic spq_pkg::req_t make_req(logic kind, logic signed [31:0] data,
                                             logic signed [31:0] key);
    spq_pkg::req_t r;
    r.req_type  = kind;
    r.item_data = data;
    r.item_key  = key;
    return r;
  endfunction

  // dequeues carry random data and key too, the block must ignore them
  function automatic spq_pkg::req_t random_req(int unsigned enq_pct);
    return make_req(($urandom_range(0, 99) < enq_pct) ? spq_pkg::REQ_ENQ : spq_pkg::REQ_DEQ,
                    $urandom, pick_key());
  endfunction

  // offer one request beat; entered and left at a falling edge
  task automatic send_req(input spq_pkg::req_t r);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       = r;
    req_valid = 1'b1;
    // beat taken at the rising edge where ready is seen high
    do @(posedge clk); while (!req_ready);
    tracker.note_request(req);
    @(negedge clk);
  endtask

  // response side: random stalls, plus the long hold when asked for
  initial begin
    int unsigned stall;
    stall     = 0;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        stall    = hold_req;
        hold_req = 0;
      end
      if (stall == 0 && !calm && $urandom_range(0, 3) == 0)
        stall = pick_gap();
      rsp_ready = (stall == 0);
      if (stall != 0)
        stall--;
    end
  end

  // every response beat is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready)
      tracker.check_response(rsp);
  end

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned len;
    int unsigned enq_pct;

    req_valid = 1'b0;
    req       = '0;
    rst       = 1'b1;
    tracker   = new(DEPTH);
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // directed: dequeue on an empty queue
    send_req(make_req(spq_pkg::REQ_DEQ, $urandom, $urandom));
    // extremes of key and data, ties at zero and at both ends
    send_req(make_req(spq_pkg::REQ_ENQ, 32'sh8000_0000, 32'sh0000_0000));
    send_req(make_req(spq_pkg::REQ_ENQ, 32'sh7fff_ffff, 32'sh7fff_ffff));
    send_req(make_req(spq_pkg::REQ_ENQ, 32'shffff_ffff, 32'sh8000_0000));
    send_req(make_req(spq_pkg::REQ_ENQ, 32'sh0000_0000, 32'shffff_ffff));
    send_req(make_req(spq_pkg::REQ_ENQ, 32'sh0000_0001, 32'sh0000_0000));
    send_req(make_req(spq_pkg::REQ_ENQ, 32'sh0000_0002, 32'sh7fff_ffff));
    send_req(make_req(spq_pkg::REQ_ENQ, 32'sh0000_0003, 32'sh8000_0000));
    // newest of the two smallest keys comes out first
    send_req(make_req(spq_pkg::REQ_DEQ, $urandom, $urandom));
    // fill up to the brim with mixed keys
    for (int i = 0; i < 10; i++)
      send_req(make_req(spq_pkg::REQ_ENQ, $urandom, (i % 2 == 0) ? 32'(i) : -32'(i)));
    // enqueue dropped when full, then a dequeue from a full queue
    send_req(make_req(spq_pkg::REQ_ENQ, 32'sh1234_5678, 32'sh0000_0000));
    send_req(make_req(spq_pkg::REQ_DEQ, $urandom, $urandom));
    repeat (3) send_req(make_req(spq_pkg::REQ_DEQ, $urandom, $urandom));

    // random phases, each with its own enqueue bias so the level sweeps
    // between empty and full many times over
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      len = $urandom_range(12, 60);
      case ($urandom_range(0, 4))
        0: enq_pct = 90;
        1: enq_pct = 70;
        2: enq_pct = 50;
        3: enq_pct = 30;
        default: enq_pct = 10;
      endcase
      calm = ($urandom_range(0, 4) == 0);
      // long receiver hold while requests keep coming, backs up the input
      if (phase == 2 || phase == 20)
        hold_req = LONG_HOLD;
      repeat (len) begin
        send_req(random_req(enq_pct));
        sent++;
      end
      phase++;
    end
    req_valid = 1'b0;
    calm      = 1'b0;

    // let the outstanding responses come home, then a short settle
    while (tracker.rsp_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.fails == 0)
      $display("sorted_priority_queue_unit regression: pass");
    else
      $display("sorted_priority_queue_unit regression: fail");
    $finish;
  end

endmodule

// File: sorted_priority_queue_unit.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_unit.sv
rtl/spq_checker.sv
tb/sv/spq_tb_pkg.sv
tb/sv/tb.sv
